// ===== rtl/mstk_pkg.sv =====
package mstk_pkg;

   localparam int TABLE_SLOTS     = 5;
   localparam int PRIORITY_LEVELS = 3;

   localparam int KEY_W   = 32;
   localparam int COUNT_W = 32;
   localparam int TLEN_W  = 6;
   localparam int BLEN_W  = 16;
   localparam int PRIO_W  = 3;
   localparam int RANK_W  = 3;
   localparam int BYTE_W  = 48;
   localparam int SLOT_W  = $clog2(TABLE_SLOTS);
   localparam int SIZE_W  = BLEN_W + 1;

   typedef enum logic {
      FUNC_RECORD = 1'b0,
      FUNC_CLEAR  = 1'b1
   } func_type;

   typedef struct packed {
      logic             update;
      logic             clear;
      logic [KEY_W-1:0] key;
   } tbl_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [SLOT_W-1:0]  rank;
      logic               inserted;
      logic               evict;
      logic [KEY_W-1:0]   evicted_key;
   } tbl_rsp_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
      return (&value) ? value : value + COUNT_W'(1);
   endfunction

endpackage

// ===== rtl/mstk_if.sv =====
interface mstk_req_if import mstk_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [KEY_W-1:0]  topic_key;
   logic [TLEN_W-1:0] topic_length;
   logic [BLEN_W-1:0] body_length;
   logic [PRIO_W-1:0] priority_req;

   modport source (output valid, func, topic_key, topic_length, body_length, priority_req,
                   input ready);
   modport sink   (input valid, func, topic_key, topic_length, body_length, priority_req,
                   output ready);
endinterface

interface mstk_rsp_if import mstk_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] topic_count;
   logic [RANK_W-1:0]  topic_rank;
   logic               was_inserted;
   logic               did_evict;
   logic [KEY_W-1:0]   evicted_key;
   logic [COUNT_W-1:0] message_total;
   logic [BYTE_W-1:0]  byte_total;
   logic [COUNT_W-1:0] priority_total;

   modport source (output valid, topic_count, topic_rank, was_inserted, did_evict, evicted_key,
                   message_total, byte_total, priority_total,
                   input ready);
   modport sink   (input valid, topic_count, topic_rank, was_inserted, did_evict, evicted_key,
                   message_total, byte_total, priority_total,
                   output ready);
endinterface

// ===== rtl/mstk_table.sv =====
module mstk_table import mstk_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  tbl_req_type tbl_req,
   output tbl_rsp_type tbl_rsp
);

   logic [KEY_W-1:0]       key_ff   [TABLE_SLOTS];
   logic [KEY_W-1:0]       key_in   [TABLE_SLOTS];
   logic [COUNT_W-1:0]     count_ff [TABLE_SLOTS];
   logic [COUNT_W-1:0]     count_in [TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [TABLE_SLOTS-1:0] valid_in;

   logic [KEY_W-1:0]       up_key   [TABLE_SLOTS];
   logic [KEY_W-1:0]       dn_key   [TABLE_SLOTS];
   logic [COUNT_W-1:0]     up_count [TABLE_SLOTS];
   logic [COUNT_W-1:0]     dn_count [TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0] up_valid;
   logic [TABLE_SLOTS-1:0] dn_valid;

   logic [TABLE_SLOTS-1:0] hit_vec;
   logic [TABLE_SLOTS-1:0] min_vec;
   logic [TABLE_SLOTS-1:0] sel_vec;
   logic [TABLE_SLOTS-1:0] ahead_vec;
   logic                   hit;
   logic                   full;
   logic [SLOT_W-1:0]      pos;
   logic [SLOT_W-1:0]      rank;
   logic [COUNT_W-1:0]     new_count;

   // Table is kept sorted with valid slots first, so the minimum sits at the tail.
   always_comb begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         hit_vec[i] = valid_ff[i] && (key_ff[i] == tbl_req.key);
         min_vec[i] = (count_ff[i] == count_ff[TABLE_SLOTS-1]);
      end
      hit  = |hit_vec;
      full = &valid_ff;
      if (hit) begin
         sel_vec = hit_vec;
      end else if (full) begin
         sel_vec = min_vec;
      end else begin
         sel_vec = ~valid_ff;
      end
      pos = '0;
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
         if (sel_vec[i]) begin
            pos = SLOT_W'(i);
         end
      end
      new_count = hit ? sat_inc(count_ff[pos]) : COUNT_W'(1);
      // stable placement: earlier slots stay ahead on ties, later ones only if larger
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (SLOT_W'(i) < pos) begin
            ahead_vec[i] = (count_ff[i] >= new_count);
         end else if (SLOT_W'(i) > pos) begin
            ahead_vec[i] = (count_ff[i] > new_count);
         end else begin
            ahead_vec[i] = 1'b0;
         end
      end
      rank = SLOT_W'($countones(ahead_vec));
   end

   for (genvar k = 0; k < TABLE_SLOTS; k++) begin : g_shift
      if (k == 0) begin : g_first
         assign up_key[k]   = key_ff[k];
         assign up_count[k] = count_ff[k];
         assign up_valid[k] = valid_ff[k];
      end else begin : g_rest
         assign up_key[k]   = key_ff[k-1];
         assign up_count[k] = count_ff[k-1];
         assign up_valid[k] = valid_ff[k-1];
      end
      if (k == TABLE_SLOTS - 1) begin : g_last
         assign dn_key[k]   = key_ff[k];
         assign dn_count[k] = count_ff[k];
         assign dn_valid[k] = valid_ff[k];
      end else begin : g_head
         assign dn_key[k]   = key_ff[k+1];
         assign dn_count[k] = count_ff[k+1];
         assign dn_valid[k] = valid_ff[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < TABLE_SLOTS; k++) begin
         if (tbl_req.clear) begin
            key_in[k]   = '0;
            count_in[k] = '0;
            valid_in[k] = 1'b0;
         end else if (!tbl_req.update) begin
            key_in[k]   = key_ff[k];
            count_in[k] = count_ff[k];
            valid_in[k] = valid_ff[k];
         end else if (SLOT_W'(k) == rank) begin
            key_in[k]   = tbl_req.key;
            count_in[k] = new_count;
            valid_in[k] = 1'b1;
         end else if ((rank <= pos) && (SLOT_W'(k) > rank) && (SLOT_W'(k) <= pos)) begin
            key_in[k]   = up_key[k];
            count_in[k] = up_count[k];
            valid_in[k] = up_valid[k];
         end else if ((rank > pos) && (SLOT_W'(k) >= pos) && (SLOT_W'(k) < rank)) begin
            key_in[k]   = dn_key[k];
            count_in[k] = dn_count[k];
            valid_in[k] = dn_valid[k];
         end else begin
            key_in[k]   = key_ff[k];
            count_in[k] = count_ff[k];
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int k = 0; k < TABLE_SLOTS; k++) begin
            key_ff[k]   <= '0;
            count_ff[k] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         for (int k = 0; k < TABLE_SLOTS; k++) begin
            key_ff[k]   <= key_in[k];
            count_ff[k] <= count_in[k];
         end
      end
   end

   assign tbl_rsp.count       = new_count;
   assign tbl_rsp.rank        = rank;
   assign tbl_rsp.inserted    = !hit;
   assign tbl_rsp.evict       = !hit && full;
   assign tbl_rsp.evicted_key = (!hit && full) ? key_ff[pos] : '0;

endmodule

// ===== rtl/message_stats_top_k_tracker.sv =====
// Message statistics with a top-K topic table. One message or clear is taken per
// cycle; a result passes the input register, then the result register, and the rate
// holds at one per cycle as long as the result side is ready.
// The rate is set by the table update: key compare, slot choice, increment and
// re-sort of all slots are combinational so the next message sees the new table.
module message_stats_top_k_tracker import mstk_pkg::*; (
   input logic         clock,
   input logic         reset,
   mstk_req_if.sink    req_chan,
   mstk_rsp_if.source  rsp_chan
);

   logic              s1_valid_ff, s1_valid_in;
   func_type          s1_func_ff;
   logic [KEY_W-1:0]  s1_key_ff;
   logic [TLEN_W-1:0] s1_tlen_ff;
   logic [BLEN_W-1:0] s1_blen_ff;
   logic [PRIO_W-1:0] s1_prio_ff;

   logic               out_valid_ff, out_valid_in;
   logic [COUNT_W-1:0] out_count_ff;
   logic [RANK_W-1:0]  out_rank_ff;
   logic               out_inserted_ff;
   logic               out_evict_ff;
   logic [KEY_W-1:0]   out_evicted_ff;
   logic [COUNT_W-1:0] out_msg_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic [COUNT_W-1:0] out_prio_ff;

   logic [COUNT_W-1:0] msg_ff, msg_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic [COUNT_W-1:0] prio_ff [PRIORITY_LEVELS];
   logic [COUNT_W-1:0] prio_in [PRIORITY_LEVELS];

   logic                   accept;
   logic                   advance;
   logic                   record;
   logic                   clear;
   logic [SIZE_W-1:0]      msg_size;
   logic [BYTE_W:0]        byte_sum;
   logic [COUNT_W-1:0]     prio_total;
   tbl_req_type            tbl_req;
   tbl_rsp_type            tbl_rsp;

   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign record         = advance && (s1_func_ff == FUNC_RECORD);
   assign clear          = advance && (s1_func_ff == FUNC_CLEAR);

   assign tbl_req.update = record;
   assign tbl_req.clear  = clear;
   assign tbl_req.key    = s1_key_ff;

   mstk_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .tbl_rsp (tbl_rsp)
   );

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

      msg_size = SIZE_W'(s1_tlen_ff) + SIZE_W'(s1_blen_ff) + SIZE_W'(2);
      byte_sum = {1'b0, byte_ff} + (BYTE_W + 1)'(msg_size);

      if (clear) begin
         msg_in  = '0;
         byte_in = '0;
      end else if (record) begin
         msg_in  = sat_inc(msg_ff);
         byte_in = byte_sum[BYTE_W] ? '1 : byte_sum[BYTE_W-1:0];
      end else begin
         msg_in  = msg_ff;
         byte_in = byte_ff;
      end

      prio_total = '0;
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
         if (clear) begin
            prio_in[l] = '0;
         end else if (record && (s1_prio_ff == PRIO_W'(l))) begin
            prio_in[l] = sat_inc(prio_ff[l]);
         end else begin
            prio_in[l] = prio_ff[l];
         end
         if (s1_prio_ff == PRIO_W'(l)) begin
            prio_total = sat_inc(prio_ff[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         msg_ff       <= '0;
         byte_ff      <= '0;
         for (int l = 0; l < PRIORITY_LEVELS; l++) begin
            prio_ff[l] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         msg_ff       <= msg_in;
         byte_ff      <= byte_in;
         for (int l = 0; l < PRIORITY_LEVELS; l++) begin
            prio_ff[l] <= prio_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff <= func_type'(req_chan.func);
         s1_key_ff  <= req_chan.topic_key;
         s1_tlen_ff <= req_chan.topic_length;
         s1_blen_ff <= req_chan.body_length;
         s1_prio_ff <= req_chan.priority_req;
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         out_count_ff    <= '0;
         out_rank_ff     <= '0;
         out_inserted_ff <= 1'b0;
         out_evict_ff    <= 1'b0;
         out_evicted_ff  <= '0;
         out_msg_ff      <= '0;
         out_byte_ff     <= '0;
         out_prio_ff     <= '0;
      end else if (record) begin
         out_count_ff    <= tbl_rsp.count;
         out_rank_ff     <= RANK_W'(tbl_rsp.rank);
         out_inserted_ff <= tbl_rsp.inserted;
         out_evict_ff    <= tbl_rsp.evict;
         out_evicted_ff  <= tbl_rsp.evicted_key;
         out_msg_ff      <= msg_in;
         out_byte_ff     <= byte_in;
         out_prio_ff     <= prio_total;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.topic_count    = out_count_ff;
   assign rsp_chan.topic_rank     = out_rank_ff;
   assign rsp_chan.was_inserted   = out_inserted_ff;
   assign rsp_chan.did_evict      = out_evict_ff;
   assign rsp_chan.evicted_key    = out_evicted_ff;
   assign rsp_chan.message_total  = out_msg_ff;
   assign rsp_chan.byte_total     = out_byte_ff;
   assign rsp_chan.priority_total = out_prio_ff;

endmodule

// ===== rtl/mstk_checker.sv =====
module mstk_checker import mstk_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COUNT_W-1:0] topic_count,
   input logic [RANK_W-1:0]  topic_rank,
   input logic               was_inserted,
   input logic               did_evict,
   input logic [KEY_W-1:0]   evicted_key,
   input logic [COUNT_W-1:0] message_total,
   input logic [BYTE_W-1:0]  byte_total,
   input logic [COUNT_W-1:0] priority_total
);

   // stalled result must hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(topic_count) && $stable(topic_rank)
         && $stable(evicted_key) && $stable(message_total) && $stable(byte_total)
         && $stable(priority_total))
      else $error("result changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_evict_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!did_evict || was_inserted) && (did_evict || (evicted_key == '0)))
      else $error("eviction flags inconsistent");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && was_inserted |-> (topic_count == COUNT_W'(1))
         && ((TABLE_SLOTS > 8) || (topic_rank <= RANK_W'(TABLE_SLOTS - 1))))
      else $error("new topic has wrong count or rank");

   a_prio_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (priority_total <= message_total))
      else $error("priority total exceeds message total");

endmodule

bind message_stats_top_k_tracker mstk_checker u_mstk_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .topic_count    (rsp_chan.topic_count),
   .topic_rank     (rsp_chan.topic_rank),
   .was_inserted   (rsp_chan.was_inserted),
   .did_evict      (rsp_chan.did_evict),
   .evicted_key    (rsp_chan.evicted_key),
   .message_total  (rsp_chan.message_total),
   .byte_total     (rsp_chan.byte_total),
   .priority_total (rsp_chan.priority_total)
);

// ===== sim/message_stats_top_k_tracker_tb.sv =====
`timescale 1ns / 100ps

module message_stats_top_k_tracker_tb;
   import mstk_pkg::*;

   localparam int KEY_POOL    = 9;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 216;
   localparam int TIMEOUT_NS  = 2_000_000;

   typedef struct {
      logic [COUNT_W-1:0] topic_count;
      logic [RANK_W-1:0]  topic_rank;
      logic               was_inserted;
      logic               did_evict;
      logic [KEY_W-1:0]   evicted_key;
      logic [COUNT_W-1:0] message_total;
      logic [BYTE_W-1:0]  byte_total;
      logic [COUNT_W-1:0] priority_total;
   } stats_result_type;

   class topk_stats_model;
      logic [KEY_W-1:0]   slot_key   [TABLE_SLOTS];
      logic [COUNT_W-1:0] slot_count [TABLE_SLOTS];
      logic               slot_valid [TABLE_SLOTS];
      logic [COUNT_W-1:0] prio_count [PRIORITY_LEVELS];
      logic [COUNT_W-1:0] msg_count;
      logic [BYTE_W-1:0]  byte_count;
      stats_result_type   pending_results[$];
      int unsigned        errors, checked, records, clears, hits, inserts, evictions;

      function new();
         wipe();
      endfunction

      function void wipe();
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_key[i]   = '0;
            slot_count[i] = '0;
            slot_valid[i] = 1'b0;
         end
         for (int i = 0; i < PRIORITY_LEVELS; i++) prio_count[i] = '0;
         msg_count  = '0;
         byte_count = '0;
      endfunction

      function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] value);
         return (&value) ? value : value + 1'b1;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void note_request(func_type fn, logic [KEY_W-1:0] key,
                                 logic [TLEN_W-1:0] tlen, logic [BLEN_W-1:0] blen,
                                 logic [PRIO_W-1:0] prio);
         stats_result_type   res;
         logic [BYTE_W:0]    sum;
         int                 pos, empty, min_idx;
         logic [KEY_W-1:0]   tk;
         logic [COUNT_W-1:0] tc;
         logic               tv;
         res = '{default: '0};
         if (fn == FUNC_CLEAR) begin
            wipe();
            clears++;
            pending_results.push_back(res);
            return;
         end
         records++;
         msg_count = bump(msg_count);
         if (prio < PRIORITY_LEVELS) begin
            prio_count[prio]   = bump(prio_count[prio]);
            res.priority_total = prio_count[prio];
         end
         sum = {1'b0, byte_count} + tlen + blen + 2;
         byte_count = sum[BYTE_W] ? '1 : sum[BYTE_W-1:0];

         pos = -1;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_valid[i] && slot_key[i] == key) begin
               pos = i;
               slot_count[i] = bump(slot_count[i]);
               hits++;
               break;
            end
         end

         if (pos < 0) begin
            empty   = -1;
            min_idx = 0;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (!slot_valid[i]) begin
                  empty = i;
                  break;
               end
               if (slot_count[i] < slot_count[min_idx]) min_idx = i;
            end
            res.was_inserted = 1'b1;
            inserts++;
            if (empty >= 0) begin
               pos = empty;
            end else begin
               pos             = min_idx;
               res.did_evict   = 1'b1;
               res.evicted_key = slot_key[min_idx];
               evictions++;
            end
            slot_key[pos]   = key;
            slot_count[pos] = 1;
            slot_valid[pos] = 1'b1;
         end

         // stable descending bubble sort, tracking this key's slot
         for (int i = 0; i < TABLE_SLOTS - 1; i++) begin
            for (int j = 0; j < TABLE_SLOTS - 1 - i; j++) begin
               if (slot_count[j] < slot_count[j+1]) begin
                  tk = slot_key[j];
                  tc = slot_count[j];
                  tv = slot_valid[j];
                  slot_key[j]     = slot_key[j+1];
                  slot_count[j]   = slot_count[j+1];
                  slot_valid[j]   = slot_valid[j+1];
                  slot_key[j+1]   = tk;
                  slot_count[j+1] = tc;
                  slot_valid[j+1] = tv;
                  if (pos == j) pos = j + 1;
                  else if (pos == j + 1) pos = j;
               end
            end
         end

         res.topic_count   = slot_count[pos];
         res.topic_rank    = pos[RANK_W-1:0];
         res.message_total = msg_count;
         res.byte_total    = byte_count;
         pending_results.push_back(res);
      endfunction

      task report(string msg);
         $display("%0t ns: %s", $time, msg);
         errors++;
      endtask

      function string diff(string name, logic [63:0] got, logic [63:0] want);
         return $sformatf("result %0d field %s: got %0h, expected %0h", checked, name, got, want);
      endfunction

      task check_response(stats_result_type got);
         stats_result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result, topic_count %0h", got.topic_count));
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got.topic_count !== want.topic_count)
            report(diff("topic_count", got.topic_count, want.topic_count));
         if (got.topic_rank !== want.topic_rank)
            report(diff("topic_rank", got.topic_rank, want.topic_rank));
         if (got.was_inserted !== want.was_inserted)
            report(diff("was_inserted", got.was_inserted, want.was_inserted));
         if (got.did_evict !== want.did_evict)
            report(diff("did_evict", got.did_evict, want.did_evict));
         if (got.evicted_key !== want.evicted_key)
            report(diff("evicted_key", got.evicted_key, want.evicted_key));
         if (got.message_total !== want.message_total)
            report(diff("message_total", got.message_total, want.message_total));
         if (got.byte_total !== want.byte_total)
            report(diff("byte_total", got.byte_total, want.byte_total));
         if (got.priority_total !== want.priority_total)
            report(diff("priority_total", got.priority_total, want.priority_total));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   mstk_req_if req_if();
   mstk_rsp_if rsp_if();

   message_stats_top_k_tracker dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   topk_stats_model  stats = new();
   logic [KEY_W-1:0] key_pool [KEY_POOL];
   int unsigned      send_idle_pct  = 0;
   int unsigned      recv_stall_pct = 0;
   logic             hold_off;
   bit               hold_go = 1'b0;

   always #5 clock = ~clock;

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) rsp_if.ready <= 1'b0;
         else rsp_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long output hold-off, counted here
   initial begin
      hold_off = 1'b0;
      wait (hold_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin : transfer_monitor
      stats_result_type seen;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen.topic_count    = rsp_if.topic_count;
            seen.topic_rank     = rsp_if.topic_rank;
            seen.was_inserted   = rsp_if.was_inserted;
            seen.did_evict      = rsp_if.did_evict;
            seen.evicted_key    = rsp_if.evicted_key;
            seen.message_total  = rsp_if.message_total;
            seen.byte_total     = rsp_if.byte_total;
            seen.priority_total = rsp_if.priority_total;
            stats.check_response(seen);
         end
         if (req_if.valid && req_if.ready)
            stats.note_request(func_type'(req_if.func), req_if.topic_key, req_if.topic_length,
                               req_if.body_length, req_if.priority_req);
      end
   end

   task automatic send_item(func_type fn, logic [KEY_W-1:0] key, logic [TLEN_W-1:0] tlen,
                            logic [BLEN_W-1:0] blen, logic [PRIO_W-1:0] prio);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.func         <= fn;
      req_if.topic_key    <= key;
      req_if.topic_length <= tlen;
      req_if.body_length  <= blen;
      req_if.priority_req <= prio;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic run_random(int unsigned count);
      int unsigned      r;
      logic [KEY_W-1:0] key;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 75)
            key = key_pool[$urandom_range(1) ? $urandom_range(2) : $urandom_range(KEY_POOL - 1)];
         else
            key = $urandom();
         send_item((r >= 98) ? FUNC_CLEAR : FUNC_RECORD, key, TLEN_W'($urandom_range(63)),
                   BLEN_W'($urandom_range(65535)), PRIO_W'($urandom_range(7)));
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.func         = FUNC_RECORD;
      req_if.topic_key    = '0;
      req_if.topic_length = '0;
      req_if.body_length  = '0;
      req_if.priority_req = '0;
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // key zero on an empty table, field extremes, priorities zero to five
      send_item(FUNC_RECORD, 32'h0000_0000, 6'd0,  16'h0000, 3'd0);
      send_item(FUNC_RECORD, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 3'd1);
      send_item(FUNC_RECORD, 32'h0000_0000, 6'd63, 16'h0000, 3'd2);
      send_item(FUNC_RECORD, 32'hA5A5_5A5A, 6'd1,  16'h8000, 3'd3);
      send_item(FUNC_RECORD, 32'h1234_5678, 6'd32, 16'h00FF, 3'd4);
      send_item(FUNC_RECORD, 32'h0000_0001, 6'd5,  16'h0001, 3'd5);
      // table full: evictions on tied minimum, hits climbing the order
      send_item(FUNC_RECORD, 32'h8000_0000, 6'd7,  16'h0007, 3'd6);
      send_item(FUNC_RECORD, 32'h8000_0000, 6'd21, 16'h5555, 3'd7);
      send_item(FUNC_RECORD, 32'hFFFF_FFFF, 6'd42, 16'hAAAA, 3'd0);
      send_item(FUNC_RECORD, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 3'd1);
      send_item(FUNC_RECORD, 32'h0000_0002, 6'd0,  16'h0000, 3'd2);
      send_item(FUNC_RECORD, 32'h0000_0003, 6'd10, 16'h0100, 3'd0);
      send_item(FUNC_RECORD, 32'h0000_0004, 6'd11, 16'h0200, 3'd1);
      send_item(FUNC_RECORD, 32'h0000_0003, 6'd12, 16'h0300, 3'd2);
      // clear with a busy payload, then rebuild
      send_item(FUNC_CLEAR,  32'hDEAD_BEEF, 6'd63, 16'hFFFF, 3'd7);
      send_item(FUNC_RECORD, 32'hDEAD_BEEF, 6'd63, 16'hFFFF, 3'd7);
      send_item(FUNC_RECORD, 32'h0000_0000, 6'd0,  16'h0000, 3'd3);
      send_item(FUNC_RECORD, 32'hDEAD_BEEF, 6'd1,  16'h0001, 3'd0);
      send_item(FUNC_CLEAR,  32'h0000_0000, 6'd0,  16'h0000, 3'd0);
      send_item(FUNC_RECORD, 32'h0000_0000, 6'd0,  16'h0000, 3'd0);

      run_random(PHASE_ITEMS);
      send_idle_pct = 59;
      run_random(PHASE_ITEMS);
      send_idle_pct  = 0;
      recv_stall_pct = 59;
      run_random(PHASE_ITEMS);
      send_idle_pct  = 27;
      recv_stall_pct = 27;
      run_random(PHASE_ITEMS);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_go        = 1'b1;
      run_random(PHASE_ITEMS);
      req_if.valid <= 1'b0;

      while (stats.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d records and %0d clears: %0d hits, %0d new keys, %0d evictions",
               stats.records, stats.clears, stats.hits, stats.inserts, stats.evictions);
      $display("Traffic: free flow, sender gaps, output stalls, mixed, %0d-cycle output hold",
               HOLD_CYCLES);
      if (stats.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timed out with %0d results outstanding", stats.pending());
      $display("Mismatches found");
      $finish;
   end

endmodule
